[rtl/tone_square_wave_generator_assert.svh]
// assertion macros shared by the tone generator rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef TONE_SQUARE_WAVE_GENERATOR_ASSERT_SVH
`define TONE_SQUARE_WAVE_GENERATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define TSG_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define TSG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tsg_pkg.sv]
// tone generator package: field widths, codes and shared types
// no dependencies
package tsg_pkg;

    localparam int MODE_BITS  = 2;
    localparam int FREQ_BITS  = 16;
    localparam int FIELD_BITS = 16;
    localparam int CLK_BITS   = 29;
    localparam int DIV_BITS   = CLK_BITS + 1;

    localparam logic [CLK_BITS-1:0] CLK_RESET = 29'd84000000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    localparam logic [MODE_BITS-1:0] MODE_START = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_STOP  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_NONE  = 2'd3;

    typedef enum logic [1:0] {
        OP_START,
        OP_STOP,
        OP_TICK,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [FREQ_BITS-1:0] freq;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quo;
    } t_div_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_EMIT
    } t_state;

endpackage

[rtl/tsg_ifs.sv]
// channel interfaces of the tone generator: note items, results, config writes
// depends on tsg_pkg
interface tsg_note_if;
    logic                          valid;
    logic                          ready;
    logic [tsg_pkg::MODE_BITS-1:0] mode;
    logic [tsg_pkg::FREQ_BITS-1:0] note_frequency;

    modport source (output valid, output mode, output note_frequency, input ready);
    modport sink   (input valid, input mode, input note_frequency, output ready);
endinterface

interface tsg_result_if;
    logic                           valid;
    logic                           ready;
    logic                           pin_level;
    logic                           active;
    logic [tsg_pkg::FIELD_BITS-1:0] prescale;
    logic [tsg_pkg::FIELD_BITS-1:0] reload;
    logic                           clamped;

    modport source (output valid, output pin_level, output active, output prescale,
                    output reload, output clamped, input ready);
    modport sink   (input valid, input pin_level, input active, input prescale,
                    input reload, input clamped, output ready);
endinterface

interface tsg_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tsg_pkg::CLK_BITS-1:0] timer_clock_hz;

    modport source (output valid, output timer_clock_hz, input ready);
    modport sink   (input valid, input timer_clock_hz, output ready);
endinterface

[rtl/tone_square_wave_generator.sv]
// top level of the tone generator: config register, front queue and back end
// depends on tsg_pkg, tsg_ifs, tsg_front, tsg_back
//
//  channel    dir  payload                                      handshake
//  i_note     in   mode, note_frequency                         valid/ready
//  o_result   out  pin_level, active, prescale, reload, clamped valid/ready
//  i_cfg      in   timer_clock_hz                               valid/ready, always ready
//
// stop, tick and unused mode beats each pop and load a result; ticks run one per cycle
// while results are taken.
// a note start pops its beat, then holds the back end for two 30-bit divisions on the
// shared one-bit-per-cycle divider, each of 30 steps, and for the emit of its result.
// reset is synchronous and active low; all timer state clears at once.
// two-beat queue between front and back; an untaken result stalls every result load
module tone_square_wave_generator #(
    parameter int COUNTER_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsg_note_if.sink     i_note,
    tsg_result_if.source o_result,
    tsg_cfg_if.sink      i_cfg
);

    logic [tsg_pkg::CLK_BITS-1:0] r_clk_hz;
    tsg_pkg::t_head               w_head;
    logic                         w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= tsg_pkg::CLK_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_clk_hz <= i_cfg.timer_clock_hz;
        end
    end

    tsg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_note  (i_note),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    tsg_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clk_hz (r_clk_hz),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

[rtl/tsg_front.sv]
// front end: accepts note beats, classifies them and queues them for the back end
// depends on tsg_pkg and tsg_ifs
module tsg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tsg_note_if.sink        i_note,
    input  logic            i_pop,
    output tsg_pkg::t_head  o_head
);

    tsg_pkg::t_entry                   r_ent [tsg_pkg::QUEUE_DEPTH];
    logic [tsg_pkg::QPTR_BITS-1:0]     r_wp;
    logic [tsg_pkg::QPTR_BITS-1:0]     r_rp;
    logic [tsg_pkg::QCNT_BITS-1:0]     r_cnt;
    tsg_pkg::t_entry                   w_new;
    logic                              w_push;
    logic                              w_pop;

    always_comb begin
        w_new.freq = i_note.note_frequency;
        unique case (i_note.mode)
            tsg_pkg::MODE_START: begin
                w_new.op = (i_note.note_frequency == '0) ? tsg_pkg::OP_STOP
                                                         : tsg_pkg::OP_START;
            end
            tsg_pkg::MODE_STOP: w_new.op = tsg_pkg::OP_STOP;
            tsg_pkg::MODE_TICK: w_new.op = tsg_pkg::OP_TICK;
            tsg_pkg::MODE_NONE: w_new.op = tsg_pkg::OP_NOP;
            default:            w_new.op = tsg_pkg::OP_NOP;
        endcase
    end

    assign i_note.ready = (r_cnt != tsg_pkg::QCNT_BITS'(tsg_pkg::QUEUE_DEPTH));
    assign w_push       = i_note.valid && i_note.ready;
    assign w_pop        = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + tsg_pkg::QCNT_BITS'(w_push) - tsg_pkg::QCNT_BITS'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_new;
        end
    end

endmodule

[rtl/tsg_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on tsg_pkg
module tsg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsg_pkg::t_div_req i_req,
    output tsg_pkg::t_div_rsp o_rsp
);

    localparam int DW = tsg_pkg::DIV_BITS;
    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_quo;
    logic [DW:0]   w_trial;
    logic          w_fit;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= w_fit ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
            r_quo <= {r_quo[DW-2:0], w_fit};
        end
    end

endmodule

[rtl/tsg_back.sv]
// back end: runs ticks, stops, no-ops and note starts; holds timer state and result register
// depends on tsg_pkg, tsg_ifs, tsg_div and the assertion macro header
`include "tone_square_wave_generator_assert.svh"

module tsg_back #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tsg_pkg::CLK_BITS-1:0] i_clk_hz,
    input  tsg_pkg::t_head               i_head,
    output logic                         o_pop,
    tsg_result_if.source                 o_result
);

    localparam int CB = COUNTER_BITS;
    localparam int DW = tsg_pkg::DIV_BITS;
    localparam int FB = tsg_pkg::FIELD_BITS;
    localparam logic [63:0] CMAX = (64'd1 << COUNTER_BITS) - 64'd1;

    tsg_pkg::t_state   r_state, n_state;
    logic              r_level, n_level;
    logic              r_en, n_en;
    logic              r_clamp, n_clamp;
    logic [CB-1:0]     r_pval, n_pval;
    logic [CB-1:0]     r_rval, n_rval;
    logic [CB-1:0]     r_pcnt, n_pcnt;
    logic [CB-1:0]     r_mcnt, n_mcnt;
    logic [CB-1:0]     r_pnew, n_pnew;
    logic [CB-1:0]     r_rnew, n_rnew;
    logic              r_cnew, n_cnew;
    logic              r_out_valid, n_out_valid;
    logic              r_out_pin;
    logic              r_out_act;
    logic [FB-1:0]     r_out_pre;
    logic [FB-1:0]     r_out_rel;
    logic              r_out_clamp;
    logic              w_out_free;
    logic              w_load;
    tsg_pkg::t_div_req w_req;
    tsg_pkg::t_div_rsp w_rsp;
    logic [31:0]       w_pre_ext;
    logic [31:0]       w_rel_ext;

    tsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_out_free = !r_out_valid || o_result.ready;

    always_comb begin
        logic [CB-1:0] v_mnext;
        logic [DW-1:0] v_div;
        logic [DW-1:0] v_pre;
        logic [DW-1:0] v_rel;

        n_state = r_state;
        n_level = r_level;
        n_en    = r_en;
        n_clamp = r_clamp;
        n_pval  = r_pval;
        n_rval  = r_rval;
        n_pcnt  = r_pcnt;
        n_mcnt  = r_mcnt;
        n_pnew  = r_pnew;
        n_rnew  = r_rnew;
        n_cnew  = r_cnew;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        w_req   = '0;
        v_mnext = '0;
        v_div   = '0;
        v_pre   = '0;
        v_rel   = '0;

        unique case (r_state)
            tsg_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.entry.op)
                        tsg_pkg::OP_START: begin
                            o_pop     = 1'b1;
                            w_req.start = 1'b1;
                            w_req.num = DW'(i_clk_hz) + DW'(i_head.entry.freq);
                            w_req.den = DW'({i_head.entry.freq, 1'b0});
                            n_state   = tsg_pkg::ST_DIV_A;
                        end
                        tsg_pkg::OP_STOP: begin
                            if (w_out_free) begin
                                o_pop   = 1'b1;
                                w_load  = 1'b1;
                                n_en    = 1'b0;
                                n_level = 1'b0;
                            end
                        end
                        tsg_pkg::OP_TICK: begin
                            if (w_out_free) begin
                                o_pop  = 1'b1;
                                w_load = 1'b1;
                                if (r_pcnt >= r_pval) begin
                                    n_pcnt  = '0;
                                    v_mnext = (r_mcnt >= r_rval) ? '0 : r_mcnt + 1'b1;
                                    n_mcnt  = v_mnext;
                                    if (v_mnext == CB'(1) && r_en) begin
                                        n_level = !r_level;
                                    end
                                end else begin
                                    n_pcnt = r_pcnt + 1'b1;
                                end
                            end
                        end
                        tsg_pkg::OP_NOP: begin
                            if (w_out_free) begin
                                o_pop  = 1'b1;
                                w_load = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tsg_pkg::ST_DIV_A: begin
                if (w_rsp.done) begin
                    // zero divisor is clamped to one
                    v_div  = (w_rsp.quo == '0) ? DW'(1) : w_rsp.quo;
                    n_cnew = (w_rsp.quo == '0);
                    v_pre  = v_div >> COUNTER_BITS;
                    if (64'(v_pre) > CMAX) begin
                        v_pre = DW'(CMAX);
                    end
                    n_pnew      = CB'(v_pre);
                    w_req.start = 1'b1;
                    w_req.num   = v_div;
                    w_req.den   = v_pre + DW'(1);
                    n_state     = tsg_pkg::ST_DIV_B;
                end
            end
            tsg_pkg::ST_DIV_B: begin
                if (w_rsp.done) begin
                    v_rel  = w_rsp.quo - DW'(1);
                    n_rnew = (64'(v_rel) > CMAX) ? CB'(CMAX) : CB'(v_rel);
                    n_state = tsg_pkg::ST_EMIT;
                end
            end
            tsg_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_pval  = r_pnew;
                    n_rval  = r_rnew;
                    n_clamp = r_cnew;
                    n_pcnt  = '0;
                    n_mcnt  = '0;
                    n_en    = 1'b1;
                    n_state = tsg_pkg::ST_IDLE;
                end
            end
            default: n_state = tsg_pkg::ST_IDLE;
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign w_pre_ext = 32'(n_pval);
    assign w_rel_ext = 32'(n_rval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsg_pkg::ST_IDLE;
            r_level     <= 1'b0;
            r_en        <= 1'b0;
            r_clamp     <= 1'b0;
            r_pval      <= '0;
            r_rval      <= '0;
            r_pcnt      <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_en        <= n_en;
            r_clamp     <= n_clamp;
            r_pval      <= n_pval;
            r_rval      <= n_rval;
            r_pcnt      <= n_pcnt;
            r_mcnt      <= n_mcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pnew <= n_pnew;
        r_rnew <= n_rnew;
        r_cnew <= n_cnew;
        if (w_load) begin
            r_out_pin   <= n_level && n_en;
            r_out_act   <= n_en;
            r_out_pre   <= w_pre_ext[FB-1:0];
            r_out_rel   <= w_rel_ext[FB-1:0];
            r_out_clamp <= n_clamp;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.pin_level = r_out_pin;
    assign o_result.active    = r_out_act;
    assign o_result.prescale  = r_out_pre;
    assign o_result.reload    = r_out_rel;
    assign o_result.clamped   = r_out_clamp;

    `TSG_ASSERT_IMPLIES(a_idle_low, !r_en, !r_level, "pin level set while output disabled")
    `TSG_ASSERT_HOLDS(a_pcnt_range, r_pcnt <= r_pval, "prescale count beyond prescale value")
    `TSG_ASSERT_HOLDS(a_mcnt_range, r_mcnt <= r_rval, "main count beyond reload value")
    `TSG_ASSERT_IMPLIES(a_pop_valid, o_pop, i_head.valid, "queue popped while empty")
    `TSG_ASSERT_NEXT(a_start_done, r_state == tsg_pkg::ST_EMIT && w_out_free,
        r_out_valid && r_en, "note start finished without result or enable")

endmodule
